// File: rtl/gbnp_pkg.sv
// shared types and codes for the grid bucket near pair counter
// used by gbnp_ctrl, gbnp_dp and grid_bucket_near_pair_counter; no dependencies
package gbnp_pkg;

  // configuration register indexes
  localparam logic CFG_GRID_DIM = 1'b0;
  localparam logic CFG_RADIUS   = 1'b1;

  localparam int unsigned GRID_DIM_W   = 7;
  localparam int unsigned RADIUS_W     = 16;
  localparam int unsigned PAIRS_W      = 12;
  localparam int unsigned TOTAL_W      = 32;
  localparam logic [6:0]  GRID_DIM_RST = 7'd1;
  localparam logic [15:0] RADIUS_RST   = 16'd6554;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_NB,
    ST_HEAD,
    ST_WALK,
    ST_SQ,
    ST_CMP,
    ST_LINK_RD,
    ST_LINK_WR,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic cell_calc;
    logic nb_step;
    logic head_own;
    logic load_head;
    logic sq;
    logic cmp;
    logic link_wr;
    logic clr_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic full;
    logic nb_in;
    logic nb_last;
    logic s_end;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/gbnp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module gbnp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gbnp_dp.sv
// datapath: config registers, cell and distance arithmetic, counters, output register
// depends on gbnp_pkg and gbnp_ram
module gbnp_dp #(
  parameter int unsigned MAX_POINTS = 4096,
  parameter int unsigned MAX_GRID   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gbnp_pkg::cmd_t               cmd_i,
  output gbnp_pkg::sts_t               sts_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic [COORD_BITS-1:0]        x_i,
  input  logic [COORD_BITS-1:0]        y_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [gbnp_pkg::PAIRS_W-1:0] pairs_o,
  output logic [gbnp_pkg::TOTAL_W-1:0] total_o,
  output logic                         full_o
);
  import gbnp_pkg::*;

  localparam int unsigned GBW   = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int unsigned GW    = $clog2(MAX_GRID + 1);
  localparam int unsigned PIW   = $clog2(MAX_POINTS);
  localparam int unsigned PW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned PTW   = 2 * CB + PW;
  localparam int unsigned HDEP  = 1 << (2 * GBW);
  localparam int unsigned SQW   = 2 * CB + 1;
  localparam int unsigned CMPW  = (SQW > 2 * RADIUS_W) ? SQW : 2 * RADIUS_W;
  localparam logic [PW-1:0] LIST_END = PW'(MAX_POINTS);

  logic [GRID_DIM_W-1:0] grid_dim_q;
  logic [RADIUS_W-1:0]   radius_q;
  logic [CB-1:0]         x_q, y_q;
  logic [GBW-1:0]        cx_q, cy_q;
  logic [2*RADIUS_W-1:0] r2_q;
  logic                  full_q;
  logic [1:0]            di_q, dj_q;
  logic [PW-1:0]         s_q;
  logic [2*CB-1:0]       dx2_q, dy2_q;
  logic [PAIRS_W-1:0]    found_q;
  logic [TOTAL_W-1:0]    total_q;
  logic [PW-1:0]         held_q;
  logic [2*GBW-1:0]      clr_q;
  logic                  out_valid_q;
  logic [PAIRS_W-1:0]    out_pairs_q;
  logic [TOTAL_W-1:0]    out_total_q;
  logic                  out_full_q;

  logic [GW-1:0]         g;
  logic [CB+GW-1:0]      xg, yg;
  logic [GBW:0]          nxu, nyu;
  logic [GBW-1:0]        nx, ny;
  logic [2*GBW-1:0]      head_raddr, head_waddr;
  logic [PW-1:0]         head_wdata, head_rdata;
  logic                  head_we;
  logic [PTW-1:0]        pt_rdata, pt_wdata;
  logic [CB-1:0]         px, py, dx, dy;
  logic [CMPW-1:0]       dist2;
  logic                  close;

  // effective grid size
  always_comb begin
    if (grid_dim_q == '0) begin
      g = GW'(1);
    end else if ({2'b00, grid_dim_q} > 9'(MAX_GRID)) begin
      g = GW'(MAX_GRID);
    end else begin
      g = GW'(grid_dim_q);
    end
  end

  assign xg = CB'(x_q) * (CB+GW)'(g);
  assign yg = CB'(y_q) * (CB+GW)'(g);

  // neighbour coordinates offset by one so that the edge below zero stays unsigned
  assign nxu = {1'b0, cx_q} + (GBW+1)'(di_q);
  assign nyu = {1'b0, cy_q} + (GBW+1)'(dj_q);
  assign nx  = GBW'(nxu - (GBW+1)'(1));
  assign ny  = GBW'(nyu - (GBW+1)'(1));

  assign head_raddr = cmd_i.head_own ? {cx_q, cy_q} : {nx, ny};
  assign head_we    = cmd_i.clr_step | cmd_i.link_wr;
  assign head_waddr = cmd_i.clr_step ? clr_q : {cx_q, cy_q};
  assign head_wdata = cmd_i.clr_step ? LIST_END : held_q;

  gbnp_ram #(.WIDTH(PW), .DEPTH(HDEP)) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(head_waddr),
    .wdata_i(head_wdata),
    .raddr_i(head_raddr),
    .rdata_o(head_rdata)
  );

  assign pt_wdata = {head_rdata, y_q, x_q};

  gbnp_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.link_wr),
    .waddr_i(held_q[PIW-1:0]),
    .wdata_i(pt_wdata),
    .raddr_i(s_q[PIW-1:0]),
    .rdata_o(pt_rdata)
  );

  assign px    = pt_rdata[CB-1:0];
  assign py    = pt_rdata[2*CB-1:CB];
  assign dx    = (x_q > px) ? (x_q - px) : (px - x_q);
  assign dy    = (y_q > py) ? (y_q - py) : (py - y_q);
  assign dist2 = CMPW'(dx2_q) + CMPW'(dy2_q);
  assign close = dist2 < CMPW'(r2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_dim_q  <= GRID_DIM_RST;
      radius_q    <= RADIUS_RST;
      found_q     <= '0;
      total_q     <= '0;
      held_q      <= '0;
      clr_q       <= '0;
      di_q        <= '0;
      dj_q        <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GRID_DIM: grid_dim_q <= cfg_data_i[GRID_DIM_W-1:0];
          CFG_RADIUS:   radius_q   <= cfg_data_i;
          default:      ;
        endcase
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.load_in) begin
        found_q <= '0;
      end
      if (cmd_i.cell_calc) begin
        full_q <= held_q >= LIST_END;
        di_q   <= '0;
        dj_q   <= '0;
      end
      if (cmd_i.nb_step) begin
        if (dj_q == 2'd2) begin
          dj_q <= '0;
          di_q <= (di_q == 2'd2) ? 2'd0 : di_q + 1'b1;
        end else begin
          dj_q <= dj_q + 1'b1;
        end
      end
      if (cmd_i.cmp && close) begin
        if (found_q != '1) found_q <= found_q + 1'b1;
        if (total_q != '1) total_q <= total_q + 1'b1;
      end
      if (cmd_i.link_wr) begin
        held_q <= held_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q <= x_i;
      y_q <= y_i;
    end
    if (cmd_i.cell_calc) begin
      cx_q <= xg[CB +: GBW];
      cy_q <= yg[CB +: GBW];
      r2_q <= radius_q * radius_q;
    end
    if (cmd_i.load_head) begin
      s_q <= head_rdata;
    end
    if (cmd_i.sq) begin
      dx2_q <= dx * dx;
      dy2_q <= dy * dy;
    end
    if (cmd_i.cmp) begin
      s_q <= pt_rdata[PTW-1 -: PW];
    end
    if (cmd_i.out_load) begin
      out_pairs_q <= found_q;
      out_total_q <= total_q;
      out_full_q  <= full_q;
    end
  end

  assign sts_o.clr_last = clr_q == '1;
  assign sts_o.full     = held_q >= LIST_END;
  assign sts_o.nb_in    = (nxu != '0) && (nyu != '0) &&
                          (nxu <= (GBW+1)'(g)) && (nyu <= (GBW+1)'(g));
  assign sts_o.nb_last  = (di_q == 2'd2) && (dj_q == 2'd2);
  assign sts_o.s_end    = s_q >= LIST_END;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pairs_o     = out_pairs_q;
  assign total_o     = out_total_q;
  assign full_o      = out_full_q;

endmodule

// File: rtl/gbnp_ctrl.sv
// controller state machine sequencing the clear pass, search walk and insertion
// depends on gbnp_pkg
module gbnp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  gbnp_pkg::sts_t sts_i,
  output gbnp_pkg::cmd_t cmd_o
);
  import gbnp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:    if (in_valid_i) state_d = ST_CELL;
      ST_CELL:    state_d = sts_i.full ? ST_DONE : ST_NB;
      ST_NB: begin
        if (sts_i.nb_in) state_d = ST_HEAD;
        else if (sts_i.nb_last) state_d = ST_LINK_RD;
      end
      ST_HEAD:    state_d = ST_WALK;
      ST_WALK: begin
        if (!sts_i.s_end) state_d = ST_SQ;
        else state_d = sts_i.nb_last ? ST_LINK_RD : ST_NB;
      end
      ST_SQ:      state_d = ST_CMP;
      ST_CMP:     state_d = ST_WALK;
      ST_LINK_RD: state_d = ST_LINK_WR;
      ST_LINK_WR: state_d = ST_DONE;
      ST_DONE:    if (sts_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR:   cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load_in  = in_valid_i;
      end
      ST_CELL:    cmd_o.cell_calc = 1'b1;
      ST_NB:      cmd_o.nb_step = !sts_i.nb_in;
      ST_HEAD:    cmd_o.load_head = 1'b1;
      ST_WALK:    cmd_o.nb_step = sts_i.s_end;
      ST_SQ:      cmd_o.sq = 1'b1;
      ST_CMP:     cmd_o.cmp = 1'b1;
      ST_LINK_RD: cmd_o.head_own = 1'b1;
      ST_LINK_WR: begin
        cmd_o.head_own = 1'b1;
        cmd_o.link_wr  = 1'b1;
      end
      ST_DONE:    cmd_o.out_load = sts_i.out_free;
      default:    ;
    endcase
  end

endmodule

// File: rtl/grid_bucket_near_pair_counter.sv
// top level of the grid bucket near pair counter: stream ports, controller and datapath
// depends on gbnp_pkg, gbnp_ctrl, gbnp_dp (and gbnp_ram through the datapath)

// Each input beat carries one point (x, y as unsigned fractions). The block finds
// its grid cell, walks the point lists of that cell and of its in-grid neighbours,
// counts stored points strictly inside radius, links the point at the head of its
// cell and returns the count, the saturating running total and a store-full flag.
// One point at a time is worked on; each stored point walked passes through the
// shared distance unit, and the head and point memories have registered reads.
// A rejected point (store full) is not searched or linked. After reset the cell
// head memory is swept to empty, and no point is taken until the sweep ends;
// configuration writes are always taken and should be made
// only while the block is idle.
module grid_bucket_near_pair_counter #(
  parameter int unsigned MAX_POINTS = 4096,
  parameter int unsigned MAX_GRID   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [15:0]                         cfg_data_i,
  // input point beats
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // fields from bit 0: x_coord, y_coord, zero fill
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // result beats
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // fields from bit 0: pairs_found (12), total_pairs (32), zero fill
  output logic [47:0]                         m_axis_tdata,
  // fields from bit 0: store_full
  output logic                                m_axis_tuser
);
  import gbnp_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [PAIRS_W-1:0]  pairs;
  logic [TOTAL_W-1:0]  total;

  // the user changes registers only while idle, which the block does not enforce; writes are always taken
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = cmd.in_ready;

  gbnp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gbnp_dp #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_GRID  (MAX_GRID),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .x_i        (s_axis_tdata[COORD_BITS-1:0]),
    .y_i        (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .pairs_o    (pairs),
    .total_o    (total),
    .full_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, total, pairs};

  // a rejected point never reports a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> pairs == '0)
    else $error("store full beat with nonzero pair count");

  // nothing is linked into the store once it is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.link_wr |-> !sts.full)
    else $error("point stored while store full");

  // no point is taken while the head memory is still being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !s_axis_tready)
    else $error("input taken during clearing pass");

endmodule
